[rtl/a2dt_pkg.sv]
package a2dt_pkg;

  // Action codes carried by in_action
  localparam logic [1:0] ACT_ROTATE    = 2'd0;
  localparam logic [1:0] ACT_TRANSLATE = 2'd1;
  localparam logic [1:0] ACT_INV_LIN   = 2'd2;
  localparam logic [1:0] ACT_INV_FULL  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_ROT_GAIN  = 2'd0;
  localparam logic [1:0] CFG_TRN_GAIN  = 2'd1;
  localparam logic [1:0] CFG_SING_THR  = 2'd2;

  localparam int CNT_W     = 5;
  localparam int DIV_BITS  = 31;
  localparam int ROT_LAST  = 10;
  localparam int TRN_LAST  = 3;
  localparam int DET_LAST  = 3;
  localparam int SHF_LAST  = 5;
  localparam int ANG_LAST  = 1;

  localparam logic signed [31:0] ONE_Q16     = 32'sd65536;
  localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032874;
  localparam longint unsigned    INV_TWO_PI_Q32 = 64'd683565276;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ANGLE, ST_CORDIC, ST_ROT, ST_TRANS, ST_DET,
    ST_DIV_INIT, ST_DIV_CHK, ST_DIV_STEP, ST_DIV_END, ST_SHIFT, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OPA_RGAIN, OPA_TGAIN, OPA_C, OPA_S, OPA_T0, OPA_T1, OPA_T2, OPA_T3
  } opa_t;

  typedef enum logic [2:0] {
    OPB_DX, OPB_DY, OPB_L0, OPB_L1, OPB_L2, OPB_L3, OPB_O0, OPB_O1
  } opb_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_LOADNEG
  } acc_op_t;

  typedef enum logic [2:0] {
    WB_NONE, WB_ANGLE, WB_CS, WB_ROT, WB_OFF, WB_DET, WB_SHIFT
  } wb_op_t;

  typedef enum logic [2:0] {
    DIV_NONE, DIV_INIT, DIV_CHK, DIV_STEP, DIV_END
  } div_op_t;

  typedef struct packed {
    logic             accept;
    logic             mul_en;
    opa_t             opa;
    opb_t             opb;
    acc_op_t          acc_op;
    wb_op_t           wb_op;
    logic [1:0]       idx;
    logic             cordic_en;
    logic [CNT_W-1:0] iter;
    div_op_t          div_op;
    logic             out_load;
    logic             commit;
  } cmd_t;

  typedef struct packed {
    logic singular;
  } status_t;

  typedef logic [31:0] atan_lut_t [32];

  // Shift and subtract quotient, used only while building the table
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in units of 2^-32 turn, from the arctangent series in Q62
  function automatic atan_lut_t build_atan();
    atan_lut_t       tab;
    longint          rad;
    longint          term;
    longint unsigned q32;
    longint unsigned prod;
    int              e;
    for (int i = 0; i < 32; i++) begin
      if (i == 0) begin
        tab[i] = 32'd536870912;
      end else begin
        rad = 0;
        for (int k = 0; k < 32; k++) begin
          e = i * (2 * k + 1);
          if (e <= 62) begin
            term = longint'(udiv64(64'd1 << (62 - e), 64'(2 * k + 1)));
            if (k[0]) rad = rad - term;
            else rad = rad + term;
          end
        end
        q32    = (longint'(rad) + 64'sd536870912) >> 30;
        prod   = q32 * INV_TWO_PI_Q32 + 64'd2147483648;
        tab[i] = prod[63:32];
      end
    end
    return tab;
  endfunction

  localparam atan_lut_t ATAN_LUT = build_atan();

endpackage

[rtl/affine_2d_transform_engine.sv]
// Throughput: one item at a time; in_stall is high until the current item
// reaches the output register. The serial divider (one quotient bit per cycle)
// and the CORDIC iteration loop dominate the work per item. The next item is
// taken while a finished result waits in the output register.
// Reset (rst_n, synchronous, active low): identity transform, gains 1.0, threshold 66.
module affine_2d_transform_engine
  import a2dt_pkg::*;
#(
  parameter int CORDIC_STEPS = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic signed [31:0] in_dx,
  input  logic signed [31:0] in_dy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_m00,
  output logic signed [31:0] out_m10,
  output logic signed [31:0] out_m01,
  output logic signed [31:0] out_m11,
  output logic signed [31:0] out_shift_x,
  output logic signed [31:0] out_shift_y,
  output logic               out_singular
);

  cmd_t    cmd;
  status_t status;

  a2dt_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  a2dt_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_dx        (in_dx),
    .in_dy        (in_dy),
    .cmd          (cmd),
    .status       (status),
    .out_m00      (out_m00),
    .out_m10      (out_m10),
    .out_m01      (out_m01),
    .out_m11      (out_m11),
    .out_shift_x  (out_shift_x),
    .out_shift_y  (out_shift_y),
    .out_singular (out_singular)
  );

endmodule

[rtl/a2dt_dp.sv]
module a2dt_dp
  import a2dt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata,
  input  logic signed [31:0] in_dx,
  input  logic signed [31:0] in_dy,
  input  cmd_t               cmd,
  output status_t            status,
  output logic signed [31:0] out_m00,
  output logic signed [31:0] out_m10,
  output logic signed [31:0] out_m01,
  output logic signed [31:0] out_m11,
  output logic signed [31:0] out_shift_x,
  output logic signed [31:0] out_shift_y,
  output logic               out_singular
);

  function automatic logic signed [31:0] sat32(logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Configuration registers
  logic signed [31:0] rg_r, tg_r;
  logic [30:0]        thr_r;

  // Transform state and working copy
  logic signed [31:0] lin_r [4];
  logic signed [31:0] off_r [2];
  logic signed [31:0] tm_r  [4];
  logic signed [31:0] ts_r  [2];
  logic signed [31:0] dx_r, dy_r;
  logic               sing_r;

  // Shared multiplier and accumulator
  logic signed [31:0] opa, opb;
  logic signed [63:0] prod_r;
  logic signed [65:0] prod_x, acc_r, acc_nxt;

  // CORDIC
  logic signed [33:0] x_r, y_r, ph_r, xs, ys, atan_v;
  logic               neg_r;
  logic signed [31:0] c_r, s_r;
  logic signed [33:0] ph0;

  // Divider
  logic [63:0]        dmag_r;
  logic               dneg_r;
  logic [64:0]        num_r;
  logic               qneg_r, ovf_r;
  logic [63:0]        rem_r;
  logic [30:0]        nlo_r, q_r;

  // Writeback values
  logic signed [65:0] rot_sh, r16_sh, trn_sum;
  logic signed [65:0] det_neg;
  logic [63:0]        det_mag;
  logic               det_sing;
  logic signed [31:0] dnum;
  logic               dnum_flip;
  logic [31:0]        dnum_mag;
  logic [64:0]        div_r2;
  logic [31:0]        qval;
  logic signed [31:0] div_res;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rg_r  <= 32'sd65536;
      tg_r  <= 32'sd65536;
      thr_r <= 31'd66;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ROT_GAIN: rg_r  <= cfg_wdata;
        CFG_TRN_GAIN: tg_r  <= cfg_wdata;
        CFG_SING_THR: thr_r <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // Multiplier operand selection
  always_comb begin
    case (cmd.opa)
      OPA_RGAIN: opa = rg_r;
      OPA_TGAIN: opa = tg_r;
      OPA_C:     opa = c_r;
      OPA_S:     opa = s_r;
      OPA_T0:    opa = tm_r[0];
      OPA_T1:    opa = tm_r[1];
      OPA_T2:    opa = tm_r[2];
      OPA_T3:    opa = tm_r[3];
      default:   opa = rg_r;
    endcase
    case (cmd.opb)
      OPB_DX:  opb = dx_r;
      OPB_DY:  opb = dy_r;
      OPB_L0:  opb = lin_r[0];
      OPB_L1:  opb = lin_r[1];
      OPB_L2:  opb = lin_r[2];
      OPB_L3:  opb = lin_r[3];
      OPB_O0:  opb = off_r[0];
      OPB_O1:  opb = off_r[1];
      default: opb = dx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_r <= opa * opb;
  end

  // Accumulator
  assign prod_x = {{2{prod_r[63]}}, prod_r};

  always_comb begin
    case (cmd.acc_op)
      ACC_LOAD:    acc_nxt = prod_x;
      ACC_ADD:     acc_nxt = acc_r + prod_x;
      ACC_SUB:     acc_nxt = acc_r - prod_x;
      ACC_LOADNEG: acc_nxt = -prod_x;
      default:     acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Rounded results: Q46 to Q16.16, and Q32.32 to Q16.16
  assign rot_sh  = (acc_r + 66'sd536870912) >>> 30;
  assign r16_sh  = (acc_r + 66'sd32768) >>> 16;
  assign trn_sum = r16_sh + {{34{off_r[cmd.idx[0]][31]}}, off_r[cmd.idx[0]]};

  // Determinant check
  assign det_neg  = -acc_r;
  assign det_mag  = acc_r[65] ? det_neg[63:0] : acc_r[63:0];
  assign det_sing = (acc_r == 66'sd0) || (det_mag < {17'b0, thr_r, 16'b0});

  // Angle fold to a quarter turn
  always_comb begin
    ph0 = {{2{prod_r[31]}}, prod_r[31:0]};
    if (ph0 > 34'sd1073741824) ph0 = ph0 - 34'sd2147483648;
    else if (ph0 < -34'sd1073741824) ph0 = ph0 + 34'sd2147483648;
  end

  assign xs     = x_r >>> cmd.iter;
  assign ys     = y_r >>> cmd.iter;
  assign atan_v = {2'b00, ATAN_LUT[cmd.iter]};

  // CORDIC registers
  always_ff @(posedge clk) begin
    if (cmd.wb_op == WB_ANGLE) begin
      ph_r  <= ph0;
      neg_r <= (ph0 != {{2{prod_r[31]}}, prod_r[31:0]});
      x_r   <= CORDIC_K_Q30;
      y_r   <= 34'sd0;
    end else if (cmd.cordic_en) begin
      if (!ph_r[33]) begin
        x_r  <= x_r - ys;
        y_r  <= y_r + xs;
        ph_r <= ph_r - atan_v;
      end else begin
        x_r  <= x_r + ys;
        y_r  <= y_r - xs;
        ph_r <= ph_r + atan_v;
      end
    end
    if (cmd.wb_op == WB_CS) begin
      c_r <= neg_r ? 32'(-x_r) : x_r[31:0];
      s_r <= neg_r ? 32'(-y_r) : y_r[31:0];
    end
  end

  // Divider numerator: the cofactor for each inverse entry
  always_comb begin
    case (cmd.idx)
      2'd0:    begin dnum = lin_r[3]; dnum_flip = 1'b0; end
      2'd1:    begin dnum = lin_r[1]; dnum_flip = 1'b1; end
      2'd2:    begin dnum = lin_r[2]; dnum_flip = 1'b1; end
      default: begin dnum = lin_r[0]; dnum_flip = 1'b0; end
    endcase
    dnum_mag = dnum[31] ? 32'(-dnum) : dnum;
  end

  assign div_r2 = {rem_r, nlo_r[30]};
  assign qval   = {1'b0, q_r};

  always_comb begin
    if (ovf_r) div_res = qneg_r ? 32'sh80000000 : 32'sh7fffffff;
    else if (qneg_r) div_res = -$signed(qval);
    else div_res = $signed(qval);
  end

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    case (cmd.div_op)
      DIV_INIT: begin
        num_r  <= {1'b0, dnum_mag, 32'b0} + {2'b00, dmag_r[63:1]};
        qneg_r <= dnum[31] ^ dnum_flip ^ dneg_r;
      end
      DIV_CHK: begin
        rem_r <= {30'b0, num_r[64:31]};
        ovf_r <= ({30'b0, num_r[64:31]} >= dmag_r);
        nlo_r <= num_r[30:0];
        q_r   <= '0;
      end
      DIV_STEP: begin
        nlo_r <= {nlo_r[29:0], 1'b0};
        if (div_r2 >= {1'b0, dmag_r}) begin
          rem_r <= 64'(div_r2 - {1'b0, dmag_r});
          q_r   <= {q_r[29:0], 1'b1};
        end else begin
          rem_r <= div_r2[63:0];
          q_r   <= {q_r[29:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // Working copy, determinant and singular flag
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dx_r <= in_dx;
      dy_r <= in_dy;
      for (int k = 0; k < 4; k++) tm_r[k] <= lin_r[k];
      for (int k = 0; k < 2; k++) ts_r[k] <= off_r[k];
    end
    case (cmd.wb_op)
      WB_ROT:   tm_r[cmd.idx] <= sat32(rot_sh);
      WB_OFF:   ts_r[cmd.idx[0]] <= sat32(trn_sum);
      WB_SHIFT: ts_r[cmd.idx[0]] <= sat32(r16_sh);
      WB_DET: begin
        dmag_r  <= det_mag;
        dneg_r  <= acc_r[65];
        ts_r[0] <= '0;
        ts_r[1] <= '0;
        if (det_sing) begin
          tm_r[0] <= ONE_Q16;
          tm_r[1] <= '0;
          tm_r[2] <= '0;
          tm_r[3] <= ONE_Q16;
        end
      end
      default: ;
    endcase
    if (cmd.div_op == DIV_END) tm_r[cmd.idx] <= div_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sing_r <= 1'b0;
    end else if (cmd.accept) begin
      sing_r <= 1'b0;
    end else if (cmd.wb_op == WB_DET) begin
      sing_r <= det_sing;
    end
  end

  assign status.singular = sing_r;

  // Transform state, updated when a rotate or translate item retires
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_r[0] <= ONE_Q16;
      lin_r[1] <= '0;
      lin_r[2] <= '0;
      lin_r[3] <= ONE_Q16;
      off_r[0] <= '0;
      off_r[1] <= '0;
    end else if (cmd.commit) begin
      for (int k = 0; k < 4; k++) lin_r[k] <= tm_r[k];
      for (int k = 0; k < 2; k++) off_r[k] <= ts_r[k];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_m00      <= tm_r[0];
      out_m10      <= tm_r[1];
      out_m01      <= tm_r[2];
      out_m11      <= tm_r[3];
      out_shift_x  <= ts_r[0];
      out_shift_y  <= ts_r[1];
      out_singular <= sing_r;
    end
  end

endmodule

[rtl/a2dt_ctrl.sv]
module a2dt_ctrl
  import a2dt_pkg::*;
#(
  parameter int CORDIC_STEPS = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  output logic       out_valid,
  input  logic       out_stall,
  input  status_t    status,
  output cmd_t       cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       div_k_r, div_k_nxt;
  logic [1:0]       action_r, action_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Next state
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r + 1'b1;
    div_k_nxt  = div_k_r;
    action_nxt = action_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          action_nxt = in_action;
          case (in_action)
            ACT_ROTATE:    state_nxt = ST_ANGLE;
            ACT_TRANSLATE: state_nxt = ST_TRANS;
            default:       state_nxt = ST_DET;
          endcase
        end
      end
      ST_ANGLE: begin
        if (cnt_r == CNT_W'(ANG_LAST)) begin
          state_nxt = ST_CORDIC;
          cnt_nxt   = '0;
        end
      end
      ST_CORDIC: begin
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
          state_nxt = ST_ROT;
          cnt_nxt   = '0;
        end
      end
      ST_ROT:   if (cnt_r == CNT_W'(ROT_LAST)) state_nxt = ST_DONE;
      ST_TRANS: if (cnt_r == CNT_W'(TRN_LAST)) state_nxt = ST_DONE;
      ST_DET: begin
        if (cnt_r == CNT_W'(DET_LAST)) begin
          state_nxt = ST_DIV_INIT;
          div_k_nxt = '0;
        end
      end
      ST_DIV_INIT: begin
        if (status.singular) state_nxt = ST_DONE;
        else state_nxt = ST_DIV_CHK;
      end
      ST_DIV_CHK: begin
        state_nxt = ST_DIV_STEP;
        cnt_nxt   = '0;
      end
      ST_DIV_STEP: if (cnt_r == CNT_W'(DIV_BITS - 1)) state_nxt = ST_DIV_END;
      ST_DIV_END: begin
        cnt_nxt = '0;
        if (div_k_r == 2'd3) begin
          state_nxt = (action_r == ACT_INV_FULL) ? ST_SHIFT : ST_DONE;
        end else begin
          div_k_nxt = div_k_r + 1'b1;
          state_nxt = ST_DIV_INIT;
        end
      end
      ST_SHIFT: if (cnt_r == CNT_W'(SHF_LAST)) state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd      = '0;
    cmd.iter = cnt_r;
    case (state_r)
      ST_IDLE: cmd.accept = in_valid;
      ST_ANGLE: begin
        if (cnt_r == '0) begin
          cmd.mul_en = 1'b1;
          cmd.opa    = OPA_RGAIN;
          cmd.opb    = OPB_DY;
        end else begin
          cmd.wb_op = WB_ANGLE;
        end
      end
      ST_CORDIC: cmd.cordic_en = 1'b1;
      ST_ROT: begin
        // products: c*a0, s*a2, c*a2, s*a0, c*a1, s*a3, c*a3, s*a1
        case (cnt_r)
          5'd0: cmd.wb_op = WB_CS;
          5'd1: begin
            cmd.mul_en = 1'b1; cmd.opa = OPA_C; cmd.opb = OPB_L0;
          end
          5'd2: begin
            cmd.mul_en = 1'b1; cmd.opa = OPA_S; cmd.opb = OPB_L2;
            cmd.acc_op = ACC_LOAD;
          end
          5'd3: begin
            cmd.mul_en = 1'b1; cmd.opa = OPA_C; cmd.opb = OPB_L2;
            cmd.acc_op = ACC_ADD;
          end
          5'd4: begin
            cmd.mul_en = 1'b1; cmd.opa = OPA_S; cmd.opb = OPB_L0;
            cmd.acc_op = ACC_LOAD;
            cmd.wb_op  = WB_ROT; cmd.idx = 2'd0;
          end
          5'd5: begin
            cmd.mul_en = 1'b1; cmd.opa = OPA_C; cmd.opb = OPB_L1;
            cmd.acc_op = ACC_SUB;
          end
          5'd6: begin
            cmd.mul_en = 1'b1; cmd.opa = OPA_S; cmd.opb = OPB_L3;
            cmd.acc_op = ACC_LOAD;
            cmd.wb_op  = WB_ROT; cmd.idx = 2'd2;
          end
          5'd7: begin
            cmd.mul_en = 1'b1; cmd.opa = OPA_C; cmd.opb = OPB_L3;
            cmd.acc_op = ACC_ADD;
          end
          5'd8: begin
            cmd.mul_en = 1'b1; cmd.opa = OPA_S; cmd.opb = OPB_L1;
            cmd.acc_op = ACC_LOAD;
            cmd.wb_op  = WB_ROT; cmd.idx = 2'd1;
          end
          5'd9: cmd.acc_op = ACC_SUB;
          default: begin
            cmd.wb_op = WB_ROT; cmd.idx = 2'd3;
          end
        endcase
      end
      ST_TRANS: begin
        case (cnt_r)
          5'd0: begin
            cmd.mul_en = 1'b1; cmd.opa = OPA_TGAIN; cmd.opb = OPB_DX;
          end
          5'd1: begin
            cmd.mul_en = 1'b1; cmd.opa = OPA_TGAIN; cmd.opb = OPB_DY;
            cmd.acc_op = ACC_LOAD;
          end
          5'd2: begin
            cmd.acc_op = ACC_LOAD;
            cmd.wb_op  = WB_OFF; cmd.idx = 2'd0;
          end
          default: begin
            cmd.wb_op = WB_OFF; cmd.idx = 2'd1;
          end
        endcase
      end
      ST_DET: begin
        case (cnt_r)
          5'd0: begin
            cmd.mul_en = 1'b1; cmd.opa = OPA_T0; cmd.opb = OPB_L3;
          end
          5'd1: begin
            cmd.mul_en = 1'b1; cmd.opa = OPA_T1; cmd.opb = OPB_L2;
            cmd.acc_op = ACC_LOAD;
          end
          5'd2: cmd.acc_op = ACC_SUB;
          default: cmd.wb_op = WB_DET;
        endcase
      end
      ST_DIV_INIT: begin
        cmd.div_op = DIV_INIT; cmd.idx = div_k_r;
      end
      ST_DIV_CHK:  cmd.div_op = DIV_CHK;
      ST_DIV_STEP: cmd.div_op = DIV_STEP;
      ST_DIV_END: begin
        cmd.div_op = DIV_END; cmd.idx = div_k_r;
      end
      ST_SHIFT: begin
        // shift_x = -(i00*x + i01*y), shift_y = -(i10*x + i11*y)
        case (cnt_r)
          5'd0: begin
            cmd.mul_en = 1'b1; cmd.opa = OPA_T0; cmd.opb = OPB_O0;
          end
          5'd1: begin
            cmd.mul_en = 1'b1; cmd.opa = OPA_T2; cmd.opb = OPB_O1;
            cmd.acc_op = ACC_LOADNEG;
          end
          5'd2: begin
            cmd.mul_en = 1'b1; cmd.opa = OPA_T1; cmd.opb = OPB_O0;
            cmd.acc_op = ACC_SUB;
          end
          5'd3: begin
            cmd.mul_en = 1'b1; cmd.opa = OPA_T3; cmd.opb = OPB_O1;
            cmd.acc_op = ACC_LOADNEG;
            cmd.wb_op  = WB_SHIFT; cmd.idx = 2'd0;
          end
          5'd4: cmd.acc_op = ACC_SUB;
          default: begin
            cmd.wb_op = WB_SHIFT; cmd.idx = 2'd1;
          end
        endcase
      end
      ST_DONE: begin
        cmd.out_load = !out_valid_r || !out_stall;
        cmd.commit   = cmd.out_load &&
                       (action_r == ACT_ROTATE || action_r == ACT_TRANSLATE);
      end
      default: ;
    endcase
  end

  // Output valid
  always_comb begin
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      div_k_r     <= '0;
      action_r    <= ACT_ROTATE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      div_k_r     <= div_k_nxt;
      action_r    <= action_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Checks
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result load did not raise out_valid");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r != ST_IDLE))
    else $error("accepted item did not start work");

  a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CORDIC) |-> (int'(cnt_r) < CORDIC_STEPS))
    else $error("CORDIC iteration out of range");

  a_commit_kind: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (cmd.out_load &&
                    (action_r == ACT_ROTATE || action_r == ACT_TRANSLATE)))
    else $error("state committed for an inverse item");

endmodule
